/* rtl/fbq_pkg.sv */
package fbq_pkg;

    localparam int HANDLE_W = 32;
    localparam int SIZE_W   = 31;
    localparam int LIMIT_W  = 31;

    localparam logic [LIMIT_W-1:0] VOLUME_LIMIT_RESET = 31'd1000000;

    typedef struct packed {
        logic [HANDLE_W-1:0] block_handle;
        logic [SIZE_W-1:0]   block_size;
    } block_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] released_handle;
        logic [SIZE_W-1:0]   released_size;
        logic                forced_by_full;
        logic                last_release;
    } release_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch the incoming item
        logic pop;       // release the oldest entry
        logic forced;    // the pop is caused by a full ring
        logic append;    // write the latched item at the tail
        logic finish;    // flush the held result as the last one
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic full;      // ring holds QUEUE_DEPTH entries
        logic over;      // queued bytes exceed the limit, queue not empty
    } status_t;

endpackage

/* rtl/fbq_ctrl.sv */
module fbq_ctrl
    import fbq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_POP_FULL = 3'd1;
    localparam logic [2:0] S_APPEND   = 3'd2;
    localparam logic [2:0] S_CHECK    = 3'd3;
    localparam logic [2:0] S_POP_VOL  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = status.full ? S_POP_FULL : S_APPEND;
                end
            end
            S_POP_FULL:
            begin
                cmd.pop    = 1'b1;
                cmd.forced = 1'b1;
                state_next = S_APPEND;
            end
            S_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                // head read is issued this cycle; its data is used in the pop state
                if (status.over)
                begin
                    state_next = S_POP_VOL;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_POP_VOL:
            begin
                cmd.pop    = 1'b1;
                state_next = S_CHECK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

/* rtl/fbq_datapath.sv */
module fbq_datapath
    import fbq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    input  block_t             block,
    input  logic               limit_we,
    input  logic [LIMIT_W-1:0] limit_wdata,
    output status_t            status,
    output logic               strobe,
    output release_t           release_item
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int VOL_W = SIZE_W + $clog2(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

    block_t             mem [QUEUE_DEPTH];
    block_t             rd_data_reg;
    block_t             in_reg;

    logic [IDX_W-1:0]   head_reg;
    logic [IDX_W-1:0]   tail_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [VOL_W-1:0]   vol_reg;
    logic [LIMIT_W-1:0] limit_reg;

    logic               pend_valid_reg;
    release_t           pend_reg;
    logic               strobe_reg;
    release_t           out_reg;

    // store: write at the tail, read the head every cycle
    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            mem[tail_reg] <= in_reg;
        end
        rd_data_reg <= mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg <= block;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            vol_reg        <= '0;
            limit_reg      <= VOLUME_LIMIT_RESET;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            // hand the held result out on the next pop or at the end of the check
            strobe_reg <= pend_valid_reg && (cmd.pop || cmd.finish);
            if (limit_we)
            begin
                limit_reg <= limit_wdata;
            end
            if (cmd.pop)
            begin
                head_reg       <= (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                count_reg      <= count_reg - 1'b1;
                vol_reg        <= vol_reg - VOL_W'(rd_data_reg.block_size);
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.append)
            begin
                tail_reg  <= (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
                count_reg <= count_reg + 1'b1;
                vol_reg   <= vol_reg + VOL_W'(in_reg.block_size);
            end
            else if (cmd.finish)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            pend_reg.released_handle <= rd_data_reg.block_handle;
            pend_reg.released_size   <= rd_data_reg.block_size;
            pend_reg.forced_by_full  <= cmd.forced;
            pend_reg.last_release    <= 1'b0;
            // its last flag is known to be clear
            out_reg                  <= pend_reg;
        end
        else if (cmd.finish)
        begin
            out_reg.released_handle <= pend_reg.released_handle;
            out_reg.released_size   <= pend_reg.released_size;
            out_reg.forced_by_full  <= pend_reg.forced_by_full;
            out_reg.last_release    <= 1'b1;
        end
    end

    assign status.full   = (count_reg == FULL_CNT);
    assign status.over   = (vol_reg > VOL_W'(limit_reg)) && (count_reg != '0);
    assign strobe        = strobe_reg;
    assign release_item  = out_reg;

endmodule

/* rtl/freed_block_quarantine_fifo.sv */
// An item that releases nothing runs capture, append and check before busy falls; a forced
// release from a full ring adds a pop, and each volume release adds a check and a pop (head
// read, then pop). A result is strobed after the next pop or the final check; the last one
// shows in the first cycle with busy low. A new item is taken only once busy is low. Reset
// (rst_n, async low) empties the queue, clears the byte total and loads the default volume
// limit. Results last one cycle, never stalled.
module freed_block_quarantine_fifo
    import fbq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  block_t             block,
    output logic               strobe,
    output release_t           release_item,
    input  logic               limit_we,
    input  logic [LIMIT_W-1:0] limit_wdata
);

    cmd_t    cmd;
    status_t status;

    // Sequence each item: optional forced pop, append, then volume pops.
    fbq_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Hold the ring, the pointers, the byte total and the result registers.
    // One released entry is held back until the next pop or the end of the
    // check so that the final result of an item carries its last flag.
    fbq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .block        (block),
        .limit_we     (limit_we),
        .limit_wdata  (limit_wdata),
        .status       (status),
        .strobe       (strobe),
        .release_item (release_item)
    );

endmodule

/* bench/freed_block_quarantine_fifo_checker.sv */
`timescale 1ns / 1ps

module freed_block_quarantine_fifo_checker
    import fbq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  block_t             block,
    input  logic               strobe,
    input  release_t           release_item,
    input  logic               limit_we,
    input  logic [LIMIT_W-1:0] limit_wdata,
    output int                 failures,
    output int                 pending,
    output int                 releases_seen,
    output int                 forced_seen
);

    logic [HANDLE_W-1:0] handle_mem [QUEUE_DEPTH];
    logic [SIZE_W-1:0]   size_mem   [QUEUE_DEPTH];
    int                  oldest;
    int                  next_free;
    int                  held;
    logic [35:0]         queued_bytes;
    logic [LIMIT_W-1:0]  volume_cap;
    release_t            expected_releases [$];

    task automatic flag_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        failures++;
    endtask

    task automatic release_oldest(input logic forced);
        release_t r;
        r.released_handle = handle_mem[oldest];
        r.released_size   = size_mem[oldest];
        r.forced_by_full  = forced;
        r.last_release    = 1'b0;
        queued_bytes = (queued_bytes >= r.released_size) ? queued_bytes - r.released_size : '0;
        oldest = (oldest == QUEUE_DEPTH - 1) ? 0 : oldest + 1;
        held--;
        expected_releases.push_back(r);
    endtask

    // Append one freed block and queue every release it causes.
    task automatic quarantine_block(input block_t b);
        int       first_new;
        release_t r;
        first_new = expected_releases.size();
        if (held >= QUEUE_DEPTH)
            release_oldest(1'b1);
        handle_mem[next_free] = b.block_handle;
        size_mem[next_free]   = b.block_size;
        next_free = (next_free == QUEUE_DEPTH - 1) ? 0 : next_free + 1;
        held++;
        queued_bytes += b.block_size;
        while (queued_bytes > volume_cap && held > 0)
            release_oldest(1'b0);
        if (expected_releases.size() > first_new)
        begin
            r = expected_releases.pop_back();
            r.last_release = 1'b1;
            expected_releases.push_back(r);
        end
    endtask

    task automatic compare_release(input release_t got);
        release_t want;
        if (expected_releases.size() == 0)
            flag_mismatch($sformatf("release of handle %h with nothing queued",
                                    got.released_handle));
        else
        begin
            want = expected_releases.pop_front();
            if (got.released_handle !== want.released_handle)
                flag_mismatch($sformatf("released_handle %h, want %h",
                                        got.released_handle, want.released_handle));
            if (got.released_size !== want.released_size)
                flag_mismatch($sformatf("released_size %h, want %h",
                                        got.released_size, want.released_size));
            if (got.forced_by_full !== want.forced_by_full)
                flag_mismatch($sformatf("forced_by_full %b, want %b",
                                        got.forced_by_full, want.forced_by_full));
            if (got.last_release !== want.last_release)
                flag_mismatch($sformatf("last_release %b, want %b",
                                        got.last_release, want.last_release));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest        = 0;
            next_free     = 0;
            held          = 0;
            queued_bytes  = '0;
            volume_cap    = VOLUME_LIMIT_RESET;
            failures      = 0;
            pending       = 0;
            releases_seen = 0;
            forced_seen   = 0;
            expected_releases.delete();
        end
        else
        begin
            // Results always belong to items accepted earlier: check them first.
            if (strobe === 1'b1)
            begin
                releases_seen++;
                if (release_item.forced_by_full === 1'b1)
                    forced_seen++;
                compare_release(release_item);
            end
            if (limit_we === 1'b1)
                volume_cap = limit_wdata;
            if (start === 1'b1 && busy === 1'b0)
                quarantine_block(block);
            pending = expected_releases.size();
        end
    end

endmodule

/* bench/freed_block_quarantine_fifo_tb.sv */
`timescale 1ns / 1ps

module freed_block_quarantine_fifo_tb;
    import fbq_pkg::*;

    localparam int QUEUE_DEPTH  = 32;
    localparam int RANDOM_ITEMS = 347;

    localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

    // Flavors of random phase; each one fixes the volume limit for its run of items.
    typedef enum int
    {
        PH_DEFAULT,     // limit at its reset value, mid-sized blocks
        PH_ZERO_CAP,    // limit zero: anything nonzero flushes the queue
        PH_FILL_RING,   // limit at full scale, small blocks: the ring fills and overflows
        PH_TIGHT_CAP,   // small random limit, frequent volume releases
        PH_WIDE_CAP     // random limit anywhere in range
    } phase_kind_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    block_t             block;
    logic               strobe;
    release_t           release_item;
    logic               limit_we;
    logic [LIMIT_W-1:0] limit_wdata;

    int failures;
    int pending;
    int releases_seen;
    int forced_seen;
    int items_sent;
    int settings_used;
    int random_sent;
    int phase_len;
    bit no_gaps;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    freed_block_quarantine_fifo #(.QUEUE_DEPTH(QUEUE_DEPTH)) DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .block        (block),
        .strobe       (strobe),
        .release_item (release_item),
        .limit_we     (limit_we),
        .limit_wdata  (limit_wdata)
    );

    freed_block_quarantine_fifo_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) release_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .block         (block),
        .strobe        (strobe),
        .release_item  (release_item),
        .limit_we      (limit_we),
        .limit_wdata   (limit_wdata),
        .failures      (failures),
        .pending       (pending),
        .releases_seen (releases_seen),
        .forced_seen   (forced_seen)
    );

    // Offer one freed block. Hold start low for a random gap unless the phase runs
    // back to back, then hold the item until a rising edge sees busy low.
    task automatic send_block(input logic [HANDLE_W-1:0] handle,
                              input logic [SIZE_W-1:0]   size);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        block <= '{block_handle: handle, block_size: size};
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        items_sent++;
    endtask

    // Drop start and wait until every predicted release has come out. An item that
    // releases nothing may still be in flight, so pause, then wait for busy to fall
    // as well.
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        while (busy !== 1'b0)
            @(negedge clk);
    endtask

    // Only ever called right after drain(), so the block is idle.
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        @(negedge clk);
        limit_we    <= 1'b1;
        limit_wdata <= value;
        @(negedge clk);
        limit_we    <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(input phase_kind_t kind, input int count);
        logic [LIMIT_W-1:0] cap;
        logic [SIZE_W-1:0]  size_top;
        logic [SIZE_W-1:0]  size;
        case (kind)
            PH_DEFAULT:   cap = VOLUME_LIMIT_RESET;
            PH_ZERO_CAP:  cap = '0;
            PH_FILL_RING: cap = LIMIT_MAX;
            PH_TIGHT_CAP: cap = LIMIT_W'($urandom_range(1, 1 << 16));
            default:      cap = LIMIT_W'($urandom);
        endcase
        // Keep most sizes a fraction of the limit so several blocks pile up before
        // the volume check kicks in; the ring-fill phase keeps 33 blocks under it.
        size_top = (kind == PH_FILL_RING) ? SIZE_W'(1 << 20) : SIZE_W'(cap / 3 + 1);
        drain();
        write_limit(cap);
        no_gaps = ($urandom_range(0, 2) == 0);
        repeat (count)
        begin
            case ($urandom_range(0, 19))
                0, 1:    size = '0;
                2:       size = SIZE_W'($urandom);
                default: size = SIZE_W'($urandom_range(0, size_top));
            endcase
            send_block($urandom, size);
            // Now and then pause the sender until the queue of releases runs dry.
            if ($urandom_range(0, 39) == 0)
                drain();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        block         = '0;
        limit_we      = 1'b0;
        limit_wdata   = '0;
        items_sent    = 0;
        settings_used = 0;
        random_sent   = 0;
        no_gaps       = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Limit at its reset value. A zero-size block stays; the largest block then
        // pushes both it and itself out; a run of mid-sized blocks crosses the limit
        // by a little, releasing only the oldest; a huge one flushes everything.
        send_block(32'h0000_0000, 31'd0);
        send_block(32'hFFFF_FFFF, 31'h7FFF_FFFF);
        send_block(32'h1234_5678, 31'd400000);
        send_block(32'h9ABC_DEF0, 31'd400000);
        send_block(32'hAAAA_AAAA, 31'd300000);
        send_block(32'h5555_5555, 31'h5555_5555);

        // Limit zero. Zero-size blocks still queue, since zero does not exceed zero;
        // a one-byte block then releases the whole queue, itself last.
        drain();
        write_limit('0);
        send_block(32'h0000_0001, 31'd0);
        send_block(32'h8000_0000, 31'd0);
        send_block(32'hCAFE_F00D, 31'd1);
        send_block(32'h0F0F_0F0F, 31'h2AAA_AAAA);

        // Limit at full scale. A block exactly at the limit stays; one more byte
        // releases it; a second full-scale block lands the total back on the limit.
        drain();
        write_limit(LIMIT_MAX);
        send_block(32'hFFFF_0000, 31'h7FFF_FFFF);
        send_block(32'h0000_FFFF, 31'd1);
        send_block(32'h1357_9BDF, 31'h7FFF_FFFF);

        // Random phases: each flavor once in order, the extremes among them, then
        // flavors at random until the item budget is spent.
        for (int k = 0; random_sent < RANDOM_ITEMS; k++)
        begin
            phase_kind_t kind;
            kind = (k < 5) ? phase_kind_t'(k) : phase_kind_t'($urandom_range(0, 4));
            phase_len = (kind == PH_FILL_RING) ? $urandom_range(40, 70)
                                               : $urandom_range(15, 45);
            if (phase_len > RANDOM_ITEMS - random_sent)
                phase_len = RANDOM_ITEMS - random_sent;
            run_phase(kind, phase_len);
            random_sent += phase_len;
        end

        // Let the last releases out, then give the block time for a stray strobe.
        drain();
        repeat (10) @(negedge clk);

        $display("%0d freed blocks quarantined across %0d limit settings, zero and full scale",
                 items_sent, settings_used);
        $display("%0d releases checked, %0d of them forced out of a full ring",
                 releases_seen, forced_seen);
        if (failures == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #(5_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
